/* rtl/scpa_pkg.sv */
// Shared types, constants and helpers for the size-class pool allocator.
package scpa_pkg;

    localparam int ADDR_W          = 17;
    localparam int REQ_W           = 16;
    localparam int CFG_W           = 14;
    localparam int NUM_REGS        = 4;
    localparam int IDX_W           = 2;
    localparam int MAX_CLASSES     = 8;
    localparam int CLASS_W         = 3;
    localparam int CLS_OUT_W       = 2;
    localparam int STATUS_W        = 2;
    localparam int BASE_CLASS_BYTES = 16;

    localparam int GRANULE_BYTES   = 16;
    localparam int PAGE_BYTES      = 8192;
    localparam int GRAN_W          = $clog2(GRANULE_BYTES);
    localparam int PAGE_W          = $clog2(PAGE_BYTES);
    localparam int LINK_W          = ADDR_W - GRAN_W;
    localparam int LINK_DEPTH      = 2 ** LINK_W;

    localparam int QUEUE_DEPTH     = 2;

    localparam int DEF_NUM_CLASSES = 4;
    localparam int DEF_NUM_PAGES   = 16;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_NOT_POOLED    = 2'd1,
        ST_OUT_OF_MEMORY = 2'd2
    } status_t;

    typedef struct packed {
        op_t               op;
        logic              no_pool;
        logic [CLASS_W-1:0] cls;
        logic [CFG_W-1:0]  size;
        logic [LINK_W-1:0] granule;
    } job_t;

    // Block size as carved: at least one granule, at most a page, granule multiple.
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [CFG_W:0] t;
        t = {1'b0, v};
        if (t < (CFG_W+1)'(GRANULE_BYTES))
        begin
            t = (CFG_W+1)'(GRANULE_BYTES);
        end
        if (t > (CFG_W+1)'(PAGE_BYTES))
        begin
            t = (CFG_W+1)'(PAGE_BYTES);
        end
        t = t + (CFG_W+1)'(GRANULE_BYTES - 1);
        t[GRAN_W-1:0] = '0;
        return t[CFG_W-1:0];
    endfunction

endpackage

/* rtl/scpa_front.sv */
// Front end: class size registers, request classification, queue push.
module scpa_front #(
    parameter int NUM_CLASSES = scpa_pkg::DEF_NUM_CLASSES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [scpa_pkg::IDX_W-1:0]    cfg_index,
    input  logic [scpa_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [scpa_pkg::REQ_W-1:0]    request_bytes,
    input  logic [scpa_pkg::ADDR_W-1:0]   block_address,
    output logic                          push_valid,
    input  logic                          push_ready,
    output scpa_pkg::job_t                push_job
);

    // effective (clamped, rounded) block size per class
    logic [scpa_pkg::CFG_W-1:0] size_reg [NUM_CLASSES];

    logic                          hit;
    logic [scpa_pkg::CLASS_W-1:0]  cls;
    logic [scpa_pkg::CFG_W-1:0]    sel_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                size_reg[i] <= scpa_pkg::eff_size(
                    scpa_pkg::CFG_W'(scpa_pkg::BASE_CLASS_BYTES << i));
            end
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                if (i < scpa_pkg::NUM_REGS && cfg_index == scpa_pkg::IDX_W'(i))
                begin
                    size_reg[i] <= scpa_pkg::eff_size(cfg_data);
                end
            end
        end
    end

    // lowest index whose block size covers the request
    always_comb
    begin
        hit      = 1'b0;
        cls      = '0;
        sel_size = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (scpa_pkg::REQ_W'(size_reg[i]) >= request_bytes)
            begin
                hit      = 1'b1;
                cls      = scpa_pkg::CLASS_W'(i);
                sel_size = size_reg[i];
            end
        end
    end

    always_comb
    begin
        push_job.op      = scpa_pkg::op_t'(op);
        push_job.no_pool = !hit;
        push_job.cls     = cls;
        push_job.size    = sel_size;
        push_job.granule = block_address[scpa_pkg::ADDR_W-1:scpa_pkg::GRAN_W];
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

/* rtl/scpa_queue.sv */
// Short job queue between front and back end.
module scpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  scpa_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output scpa_pkg::job_t pop_job
);

    localparam int PTR_W = (scpa_pkg::QUEUE_DEPTH > 1) ? $clog2(scpa_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(scpa_pkg::QUEUE_DEPTH + 1);

    scpa_pkg::job_t     slot_reg [scpa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(scpa_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(scpa_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(scpa_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/scpa_back.sv */
// Back end: free lists, link store, bump pointers, page pool, result register.
module scpa_back #(
    parameter int NUM_CLASSES = scpa_pkg::DEF_NUM_CLASSES,
    parameter int POOL_PAGES  = scpa_pkg::DEF_NUM_PAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  scpa_pkg::job_t                  pop_job,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scpa_pkg::ADDR_W-1:0]     grant_address,
    output logic [scpa_pkg::CLS_OUT_W-1:0]  size_class,
    output logic [scpa_pkg::STATUS_W-1:0]   status
);

    localparam int PG_CNT_W = $clog2(POOL_PAGES + 1);
    localparam int SUM_W    = ((scpa_pkg::PAGE_W > scpa_pkg::CFG_W)
                               ? scpa_pkg::PAGE_W : scpa_pkg::CFG_W) + 2;
    localparam int LINK_W   = scpa_pkg::LINK_W;
    localparam int ADDR_W   = scpa_pkg::ADDR_W;

    typedef enum logic {
        S_RUN,
        S_LINK
    } state_t;

    state_t                          state_reg;
    logic [scpa_pkg::CLASS_W-1:0]    link_cls_reg;
    logic                            head_valid_reg [NUM_CLASSES];
    logic [LINK_W-1:0]               head_reg       [NUM_CLASSES];
    logic                            bump_valid_reg [NUM_CLASSES];
    logic [ADDR_W-1:0]               bump_reg       [NUM_CLASSES];
    logic [PG_CNT_W-1:0]             pages_reg;
    logic                            out_valid_reg;
    logic [ADDR_W-1:0]               grant_reg;
    logic [scpa_pkg::CLS_OUT_W-1:0]  cls_reg;
    scpa_pkg::status_t               status_reg;

    logic [LINK_W:0]                 link_mem [scpa_pkg::LINK_DEPTH];
    logic [LINK_W:0]                 link_rd_reg;

    logic                            take;
    logic                            hv;
    logic [LINK_W-1:0]               hd;
    logic                            bv;
    logic [ADDR_W-1:0]               bp;
    logic [ADDR_W-1:0]               page_addr;
    logic [ADDR_W-1:0]               base_grant;
    logic [scpa_pkg::PAGE_W-1:0]     offset;
    logic                            fits_next;
    logic [ADDR_W-1:0]               next_addr;
    logic [ADDR_W-1:0]               grant_next;
    logic [scpa_pkg::CLS_OUT_W-1:0]  cls_next;
    scpa_pkg::status_t               status_next;
    logic                            mem_we;
    logic                            head_set;
    logic                            go_link;
    logic                            bump_upd;
    logic                            page_take;

    always_comb
    begin
        hv = 1'b0;
        hd = '0;
        bv = 1'b0;
        bp = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (scpa_pkg::CLASS_W'(i) == pop_job.cls)
            begin
                hv = head_valid_reg[i];
                hd = head_reg[i];
                bv = bump_valid_reg[i];
                bp = bump_reg[i];
            end
        end
    end

    assign take      = (state_reg == S_RUN) && pop_valid && (!out_valid_reg || out_ready);
    assign pop_ready = take;

    // bump pointer advance: arm only if a further block fits in this page
    assign page_addr  = ADDR_W'({pages_reg, scpa_pkg::PAGE_W'(0)});
    assign base_grant = bv ? bp : page_addr;
    assign offset     = base_grant[scpa_pkg::PAGE_W-1:0];
    assign fits_next  = (SUM_W'(offset) + SUM_W'({pop_job.size, 1'b0}))
                        <= SUM_W'(scpa_pkg::PAGE_BYTES);
    assign next_addr  = base_grant + ADDR_W'(pop_job.size);

    always_comb
    begin
        grant_next  = '0;
        cls_next    = pop_job.cls[scpa_pkg::CLS_OUT_W-1:0];
        status_next = scpa_pkg::ST_OK;
        mem_we      = 1'b0;
        head_set    = 1'b0;
        go_link     = 1'b0;
        bump_upd    = 1'b0;
        page_take   = 1'b0;
        priority if (pop_job.no_pool)
        begin
            cls_next    = '0;
            status_next = scpa_pkg::ST_NOT_POOLED;
        end
        else if (pop_job.op == scpa_pkg::OP_FREE)
        begin
            mem_we   = take;
            head_set = 1'b1;
        end
        else if (hv)
        begin
            grant_next = {hd, scpa_pkg::GRAN_W'(0)};
            go_link    = 1'b1;
        end
        else if (bv)
        begin
            grant_next = bp;
            bump_upd   = 1'b1;
        end
        else if (pages_reg < PG_CNT_W'(POOL_PAGES))
        begin
            grant_next = page_addr;
            bump_upd   = 1'b1;
            page_take  = 1'b1;
        end
        else
        begin
            status_next = scpa_pkg::ST_OUT_OF_MEMORY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            link_cls_reg  <= '0;
            pages_reg     <= '0;
            out_valid_reg <= 1'b0;
            grant_reg     <= '0;
            cls_reg       <= '0;
            status_reg    <= scpa_pkg::ST_OK;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_valid_reg[i] <= 1'b0;
                head_reg[i]       <= '0;
                bump_valid_reg[i] <= 1'b0;
                bump_reg[i]       <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RUN:
                begin
                    if (take)
                    begin
                        grant_reg     <= grant_next;
                        cls_reg       <= cls_next;
                        status_reg    <= status_next;
                        for (int i = 0; i < NUM_CLASSES; i++)
                        begin
                            if (scpa_pkg::CLASS_W'(i) == pop_job.cls)
                            begin
                                if (head_set)
                                begin
                                    head_valid_reg[i] <= 1'b1;
                                    head_reg[i]       <= pop_job.granule;
                                end
                                if (bump_upd)
                                begin
                                    bump_valid_reg[i] <= fits_next;
                                    bump_reg[i]       <= fits_next ? next_addr : '0;
                                end
                            end
                        end
                        if (page_take)
                        begin
                            pages_reg <= pages_reg + 1'b1;
                        end
                        if (go_link)
                        begin
                            state_reg    <= S_LINK;
                            link_cls_reg <= pop_job.cls;
                        end
                    end
                end
                S_LINK:
                begin
                    // popped head's successor arrives from the link store
                    for (int i = 0; i < NUM_CLASSES; i++)
                    begin
                        if (scpa_pkg::CLASS_W'(i) == link_cls_reg)
                        begin
                            head_valid_reg[i] <= link_rd_reg[LINK_W];
                            head_reg[i]       <= link_rd_reg[LINK_W-1:0];
                        end
                    end
                    state_reg <= S_RUN;
                end
                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[pop_job.granule] <= {hv, hd};
        end
        link_rd_reg <= link_mem[hd];
    end

    assign out_valid     = out_valid_reg;
    assign grant_address = grant_reg;
    assign size_class    = cls_reg;
    assign status        = status_reg;

endmodule

/* rtl/size_class_pool_allocator.sv */
// Top level of the size-class pool allocator.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    op, request_bytes, block_address
//  out      output     out_valid / out_ready  grant_address, size_class, status
//  cfg      input      cfg_write              cfg_index, cfg_data
//
// The front end classifies a request in the cycle it is accepted and queues it
// (two entries). The back end retires one transaction per cycle unless the
// output stalls; a free-list allocation also passes a link state (link store
// read, then head update). A result passes the queue slot and result register.
// Reset empties all free lists and bump pointers and the page count; the link
// store is not cleared, so the block is ready right after reset.
// A stalled output holds its result; the queue keeps taking requests until full.
module size_class_pool_allocator #(
    parameter int NUM_CLASSES = scpa_pkg::DEF_NUM_CLASSES,
    parameter int POOL_PAGES  = scpa_pkg::DEF_NUM_PAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [scpa_pkg::IDX_W-1:0]      cfg_index,
    input  logic [scpa_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [scpa_pkg::REQ_W-1:0]      request_bytes,
    input  logic [scpa_pkg::ADDR_W-1:0]     block_address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scpa_pkg::ADDR_W-1:0]     grant_address,
    output logic [scpa_pkg::CLS_OUT_W-1:0]  size_class,
    output logic [scpa_pkg::STATUS_W-1:0]   status
);

    logic           push_valid;
    logic           push_ready;
    scpa_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    scpa_pkg::job_t pop_job;

    scpa_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .request_bytes (request_bytes),
        .block_address (block_address),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    scpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    scpa_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .POOL_PAGES  (POOL_PAGES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_job       (pop_job),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .grant_address (grant_address),
        .size_class    (size_class),
        .status        (status)
    );

endmodule

/* rtl/scpa_checker.sv */
// Port-level checks for the size-class pool allocator, bound to the top level.
module scpa_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            op,
    input  logic [scpa_pkg::REQ_W-1:0]      request_bytes,
    input  logic [scpa_pkg::ADDR_W-1:0]     block_address,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [scpa_pkg::ADDR_W-1:0]     grant_address,
    input  logic [scpa_pkg::CLS_OUT_W-1:0]  size_class,
    input  logic [scpa_pkg::STATUS_W-1:0]   status
);

    // waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op)
                                  && $stable(request_bytes) && $stable(block_address))
        else $error("request changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(grant_address)
                                    && $stable(size_class) && $stable(status))
        else $error("output changed while stalled");

    a_not_pooled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == scpa_pkg::ST_NOT_POOLED
        |-> grant_address == '0 && size_class == '0)
        else $error("not_pooled result carries address or class");

    a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == scpa_pkg::ST_OUT_OF_MEMORY |-> grant_address == '0)
        else $error("out_of_memory result carries an address");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == scpa_pkg::ST_OK
        |-> grant_address[scpa_pkg::GRAN_W-1:0] == '0)
        else $error("granted address not granule aligned");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);
